@@ hdl/priority_ready_queue_scheduler_unit_macros.svh @@
// Assertion macros shared by the scheduler modules.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PRQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication checked in the cycle after the antecedent.
`define PRQS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hdl/prqs_pkg.sv @@
package prqs_pkg;
	// Sizes fixed by the 5-bit thread and priority fields of the stream beats.
	localparam int PRIORITY_LEVELS = 32;
	localparam int THREAD_SLOTS    = 32;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_YIELD    = 2'd2,
		CMD_SCHEDULE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_DUP     = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_APPEND,
		S_SCHED,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic read;
		logic unlink;
		logic append;
		logic sched;
		logic load_out;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic    do_op;
		logic    is_yield;
		logic    is_sched;
	} dp_stat_t;
endpackage

@@ hdl/prqs_ctrl.sv @@
`include "priority_ready_queue_scheduler_unit_macros.svh"
module prqs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_free,
	input  prqs_pkg::dp_stat_t  stat,
	output prqs_pkg::ctrl_t     ctrl,
	output logic                busy
);
	prqs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prqs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		busy    = 1'b1;
		unique case (state_q)
			prqs_pkg::S_IDLE: begin
				busy = 1'b0;
				ctrl.capture = in_fire;
				if (in_fire) begin
					state_d = prqs_pkg::S_READ;
				end
			end
			prqs_pkg::S_READ: begin
				ctrl.read = 1'b1;
				state_d = prqs_pkg::S_EXEC;
			end
			prqs_pkg::S_EXEC: begin
				if (stat.is_sched) begin
					ctrl.sched = 1'b1;
					state_d = prqs_pkg::S_OUT;
				end else if (stat.do_op) begin
					ctrl.unlink = 1'b1;
					state_d = stat.is_yield ? prqs_pkg::S_APPEND : prqs_pkg::S_OUT;
				end else begin
					state_d = prqs_pkg::S_OUT;
				end
			end
			prqs_pkg::S_APPEND: begin
				ctrl.append = 1'b1;
				state_d = prqs_pkg::S_SCHED;
			end
			prqs_pkg::S_SCHED: begin
				ctrl.sched = 1'b1;
				state_d = prqs_pkg::S_OUT;
			end
			prqs_pkg::S_OUT: begin
				if (out_free) begin
					ctrl.load_out = 1'b1;
					state_d = prqs_pkg::S_IDLE;
				end
			end
			default: state_d = prqs_pkg::S_IDLE;
		endcase
	end

	`PRQS_ASSERT_NXT(a_cap_read, clk, arst_n, ctrl.capture, state_q == prqs_pkg::S_READ,
		"capture not followed by read")
	`PRQS_ASSERT_NXT(a_app_sched, clk, arst_n, ctrl.append, ctrl.sched,
		"append not followed by schedule")
	`PRQS_ASSERT_IMP(a_idle_free, clk, arst_n, state_q == prqs_pkg::S_IDLE, !busy,
		"idle but busy")
endmodule

@@ hdl/prqs_dp.sv @@
`include "priority_ready_queue_scheduler_unit_macros.svh"
module prqs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  prqs_pkg::ctrl_t    ctrl,
	input  logic [1:0]         in_cmd,
	input  logic [4:0]         in_tid,
	input  logic [4:0]         in_prio,
	output prqs_pkg::dp_stat_t stat,
	output logic               res_switch,
	output logic               res_has_prev,
	output logic [4:0]         res_prev,
	output logic [4:0]         res_next,
	output logic [31:0]        res_mask,
	output prqs_pkg::status_t  res_status
);
	localparam int TW = (prqs_pkg::THREAD_SLOTS > 1) ? $clog2(prqs_pkg::THREAD_SLOTS) : 1;
	localparam int PW = (prqs_pkg::PRIORITY_LEVELS > 1) ? $clog2(prqs_pkg::PRIORITY_LEVELS) : 1;

	// Small pointer tables; read at data-chosen addresses as flop arrays of 32 or fewer.
	logic [TW-1:0] link_next_q [prqs_pkg::THREAD_SLOTS];
	logic [TW-1:0] link_prev_q [prqs_pkg::THREAD_SLOTS];
	logic [TW-1:0] head_q [prqs_pkg::PRIORITY_LEVELS];
	logic [TW-1:0] tail_q [prqs_pkg::PRIORITY_LEVELS];
	logic [PW-1:0] prio_q [prqs_pkg::THREAD_SLOTS];
	logic [prqs_pkg::THREAD_SLOTS-1:0]    queued_q;
	logic [prqs_pkg::PRIORITY_LEVELS-1:0] ready_q;
	logic [TW-1:0] cur_q;
	logic          cur_v_q;

	logic [1:0]  cmd_q;
	logic [4:0]  tid_q, pri_q;
	// Operands read in the read state.
	logic [TW-1:0] t_q;
	logic [PW-1:0] p_q;
	logic [TW-1:0] h_q, tl_q, ln_q, lp_q;
	logic          rb_q;
	prqs_pkg::status_t st_q;
	logic          do_q;
	logic          sw_q, hp_q;
	logic [TW-1:0] pt_q;

	logic          t_ok, p_ok;
	logic [TW-1:0] t_sel;
	logic [PW-1:0] p_sel;
	logic          fe_any;
	logic [PW-1:0] fe_idx;

	assign t_ok = {27'd0, tid_q} < 32'(prqs_pkg::THREAD_SLOTS);
	assign p_ok = {27'd0, pri_q} < 32'(prqs_pkg::PRIORITY_LEVELS);

	always_comb begin
		t_sel = cur_q;
		p_sel = prio_q[cur_q];
		unique case (prqs_pkg::cmd_t'(cmd_q))
			prqs_pkg::CMD_INSERT: begin
				t_sel = tid_q[TW-1:0];
				p_sel = pri_q[PW-1:0];
			end
			prqs_pkg::CMD_REMOVE: begin
				t_sel = tid_q[TW-1:0];
				p_sel = prio_q[tid_q[TW-1:0]];
			end
			default: ;
		endcase
	end

	// Lowest set ready bit.
	always_comb begin
		fe_any = 1'b0;
		fe_idx = '0;
		for (int i = prqs_pkg::PRIORITY_LEVELS - 1; i >= 0; i--) begin
			if (ready_q[i]) begin
				fe_any = 1'b1;
				fe_idx = PW'(i);
			end
		end
	end

	assign stat.do_op      = do_q;
	assign stat.is_yield   = cmd_q == prqs_pkg::CMD_YIELD;
	assign stat.is_sched   = cmd_q == prqs_pkg::CMD_SCHEDULE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q <= '0;
			ready_q  <= '0;
			cur_q    <= '0;
			cur_v_q  <= 1'b0;
			sw_q     <= 1'b0;
			hp_q     <= 1'b0;
			pt_q     <= '0;
			do_q     <= 1'b0;
			st_q     <= prqs_pkg::ST_OK;
		end else begin
			if (ctrl.capture) begin
				sw_q <= 1'b0;
				hp_q <= 1'b0;
				pt_q <= '0;
			end
			if (ctrl.read) begin
				do_q <= 1'b0;
				st_q <= prqs_pkg::ST_OK;
				unique case (prqs_pkg::cmd_t'(cmd_q))
					prqs_pkg::CMD_INSERT: begin
						if (!t_ok || !p_ok) begin
							st_q <= prqs_pkg::ST_INVALID;
						end else if (queued_q[tid_q[TW-1:0]]) begin
							st_q <= prqs_pkg::ST_DUP;
						end else begin
							do_q <= 1'b1;
						end
					end
					prqs_pkg::CMD_REMOVE: begin
						if (!t_ok || !queued_q[tid_q[TW-1:0]]) begin
							st_q <= prqs_pkg::ST_INVALID;
						end else begin
							do_q <= 1'b1;
						end
					end
					prqs_pkg::CMD_YIELD: begin
						if (!cur_v_q || !queued_q[cur_q]) begin
							st_q <= prqs_pkg::ST_INVALID;
						end else if (!(head_q[p_sel] == cur_q && tail_q[p_sel] == cur_q)) begin
							do_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (ctrl.unlink) begin
				if (cmd_q == prqs_pkg::CMD_INSERT) begin
					queued_q[t_q] <= 1'b1;
					ready_q[p_q]  <= 1'b1;
				end else begin
					if (cmd_q == prqs_pkg::CMD_REMOVE) begin
						queued_q[t_q] <= 1'b0;
					end
					if (h_q == t_q && tl_q == t_q) begin
						ready_q[p_q] <= 1'b0;
					end
				end
			end
			if (ctrl.sched) begin
				if (!fe_any) begin
					st_q <= prqs_pkg::ST_EMPTY;
				end else if (!(cur_v_q && cur_q == head_q[fe_idx])) begin
					sw_q    <= 1'b1;
					hp_q    <= cur_v_q;
					pt_q    <= cur_v_q ? cur_q : '0;
					cur_q   <= head_q[fe_idx];
					cur_v_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers and link tables.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= in_cmd;
			tid_q <= in_tid;
			pri_q <= in_prio;
		end
		if (ctrl.read) begin
			t_q  <= t_sel;
			p_q  <= p_sel;
			h_q  <= head_q[p_sel];
			tl_q <= tail_q[p_sel];
			ln_q <= link_next_q[t_sel];
			lp_q <= link_prev_q[t_sel];
			rb_q <= ready_q[p_sel];
		end
		if (ctrl.unlink) begin
			if (cmd_q == prqs_pkg::CMD_INSERT) begin
				// The priority is recorded only once the insert is known to be accepted.
				prio_q[t_q] <= p_q;
				if (rb_q) begin
					link_next_q[tl_q] <= t_q;
					link_prev_q[t_q]  <= tl_q;
				end else begin
					head_q[p_q] <= t_q;
				end
				tail_q[p_q] <= t_q;
			end else if (h_q == t_q && tl_q == t_q) begin
			end else if (h_q == t_q) begin
				head_q[p_q] <= ln_q;
			end else if (tl_q == t_q) begin
				tail_q[p_q] <= lp_q;
			end else begin
				link_next_q[lp_q] <= ln_q;
				link_prev_q[ln_q] <= lp_q;
			end
		end
		if (ctrl.append) begin
			// Yield re-append: queue is non-empty since the thread was not alone.
			link_next_q[tail_q[p_q]] <= t_q;
			link_prev_q[t_q]         <= tail_q[p_q];
			tail_q[p_q]              <= t_q;
		end
	end

	always_comb begin
		res_switch   = sw_q;
		res_has_prev = hp_q;
		res_prev     = 5'(pt_q);
		res_next     = cur_v_q ? 5'(cur_q) : 5'd0;
		res_mask     = 32'(ready_q);
		res_status   = st_q;
	end

	`PRQS_ASSERT_IMP(a_ready_q, clk, arst_n, queued_q == '0, ready_q == '0,
		"ready bit without queued thread")
	`PRQS_ASSERT_NXT(a_sw_cur, clk, arst_n, ctrl.sched && fe_any, cur_v_q,
		"schedule left no current thread")
	`PRQS_ASSERT_IMP(a_hp_sw, clk, arst_n, hp_q, sw_q,
		"has_prev without switch")
endmodule

@@ hdl/priority_ready_queue_scheduler_unit.sv @@
// An accepted command passes the read and execute steps of the controller over the link tables,
// then waits in the output step for a free output register; a yield that moves the thread takes
// the append and schedule steps between execute and output. A new beat is taken only while idle.
// A finished result waits in the output register while the next beat is accepted.
// Reset (arst_n low) clears the queued flags, ready bitmap, current thread and the handshake;
// the link and head/tail tables are not cleared and hold only what commands have written.
`include "priority_ready_queue_scheduler_unit_macros.svh"
module priority_ready_queue_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [1:0] cmd, [6:2] thread_id, [11:7] priority_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // [0] switch_req, [1] has_prev, [6:2] prev_tid,
	                              // [11:7] next_tid, [43:12] ready_mask, [45:44] status
);
	prqs_pkg::ctrl_t    ctrl;
	prqs_pkg::dp_stat_t stat;
	logic               busy;
	logic               in_fire;
	logic               out_free;
	logic               r_sw, r_hp;
	logic [4:0]         r_pt, r_nt;
	logic [31:0]        r_mask;
	prqs_pkg::status_t  r_st;
	logic [47:0]        out_q;
	logic               out_v_q;

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	// The output register is free when empty or being drained this cycle.
	assign out_free = !out_v_q || m_tready;

	prqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.stat     (stat),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	prqs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.in_cmd       (s_tdata[1:0]),
		.in_tid       (s_tdata[6:2]),
		.in_prio      (s_tdata[11:7]),
		.stat         (stat),
		.res_switch   (r_sw),
		.res_has_prev (r_hp),
		.res_prev     (r_pt),
		.res_next     (r_nt),
		.res_mask     (r_mask),
		.res_status   (r_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_q <= {2'b00, r_st, r_mask, r_nt, r_pt, r_hp, r_sw};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	`PRQS_ASSERT_IMP(a_load_free, clk, arst_n, ctrl.load_out, out_free,
		"result overwrote an untaken beat")
	`PRQS_ASSERT_IMP(a_fire_idle, clk, arst_n, in_fire, ctrl.capture,
		"accepted beat not captured")
	`PRQS_ASSERT_NXT(a_load_valid, clk, arst_n, ctrl.load_out, m_tvalid,
		"loaded result not presented")
endmodule
